[design/stun_val_pkg.sv]
// shared types and constants for the stun message validator
package stun_val_pkg;

    localparam logic [31:0] FP_XOR      = 32'h5354554e;
    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [16:0] HDR_LEN     = 17'd20;
    localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
    localparam int          ATTR_BITS   = 11;

    typedef enum logic [3:0] {
        V_OK        = 4'd0,
        V_NOT_STUN  = 4'd1,
        V_LEN_MISM  = 4'd2,
        V_OVERRUN   = 4'd3,
        V_AFTER_FP  = 4'd4,
        V_AFTER_MI  = 4'd5,
        V_BAD_LEN   = 4'd6,
        V_DUP       = 4'd7,
        V_FP_MISM   = 4'd8
    } verdict_t;

    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_SKIP = 2'd1,
        PH_FP   = 2'd2
    } phase_t;

    localparam logic [0:0] CFG_USERNAME = 1'b0;
    localparam logic [0:0] CFG_SOFTWARE = 1'b1;

    // one queue entry between the front and the back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // closing data of one message, from parser to result register
    typedef struct packed {
        logic [3:0]  verdict;
        logic [1:0]  msg_class;
        logic [11:0] msg_method;
        logic [10:0] attrs_present;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[design/stun_val_fifo.sv]
// short queue of input bytes between the front and the back
module stun_val_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  stun_val_pkg::item_t in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output stun_val_pkg::item_t out_item
);
    import stun_val_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_stall  = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[design/stun_val_parser.sv]
// back part: header checks, attribute walk, crc and verdict
module stun_val_parser (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  stun_val_pkg::item_t     in_item,
    input  logic [15:0]             username_max_len,
    input  logic [15:0]             software_max_len,
    output logic                    out_valid,
    input  logic                    out_stall,
    output stun_val_pkg::result_t   out_res
);
    import stun_val_pkg::*;

    logic [16:0] byte_count_reg, byte_count_next;
    logic [15:0] type_field_reg, type_field_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic        header_ok_reg, header_ok_next;
    logic [31:0] ahdr_reg, ahdr_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] skip_reg, skip_next;
    logic [ATTR_BITS-1:0] seen_reg, seen_next;
    logic [3:0]  ferr_reg, ferr_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] snap_reg, snap_next;
    logic [31:0] fp_reg, fp_next;
    logic        ovalid_reg;
    result_t     res_reg, res_next;

    logic        take;
    logic [7:0]  b;
    logic [16:0] pos, rel;
    logic [15:0] at, an;
    logic [17:0] end_pos;
    logic [3:0]  bit_idx;
    logic        known, lok;
    logic [15:0] pad_len;

    // result register frees as it is taken, so a new byte can enter alongside
    assign in_stall  = ovalid_reg && out_stall;
    assign take      = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign out_res   = res_reg;

    assign b   = in_item.data_byte;
    assign pos = byte_count_reg;
    assign rel = pos - HDR_LEN;

    always_comb
    begin
        at = ahdr_reg[23:8];
        an = {ahdr_reg[7:0], b};
        end_pos = {1'b0, rel} + 18'd1 + {2'd0, an};
        known = 1'b1;
        case (at)
            16'h0006: bit_idx = 4'd0;
            16'h0024: bit_idx = 4'd1;
            16'h802A: bit_idx = 4'd2;
            16'h8029: bit_idx = 4'd3;
            16'h0025: bit_idx = 4'd4;
            16'hC001: bit_idx = 4'd5;
            16'h8022: bit_idx = 4'd6;
            16'h0020: bit_idx = 4'd7;
            16'h0009: bit_idx = 4'd8;
            16'h0008: bit_idx = 4'd9;
            16'h8028: bit_idx = 4'd10;
            default:
            begin
                bit_idx = 4'd0;
                known   = 1'b0;
            end
        endcase
        case (bit_idx)
            4'd0:    lok = an <= username_max_len;
            4'd1:    lok = an == 16'd4;
            4'd2:    lok = an == 16'd8;
            4'd3:    lok = an == 16'd8;
            4'd4:    lok = an == 16'd0;
            4'd5:    lok = an == 16'd4;
            4'd6:    lok = an <= software_max_len;
            4'd7:    lok = an == 16'd8 || an == 16'd20;
            4'd8:    lok = an >= 16'd4;
            4'd9:    lok = an == 16'd20;
            default: lok = an == 16'd4;
        endcase
        pad_len = (an + 16'd3) & 16'hFFFC;
    end

    always_comb
    begin
        logic [16:0] total;
        logic [15:0] tf;
        byte_count_next = byte_count_reg;
        type_field_next = type_field_reg;
        decl_len_next   = decl_len_reg;
        header_ok_next  = header_ok_reg;
        ahdr_next       = ahdr_reg;
        phase_next      = phase_reg;
        skip_next       = skip_reg;
        seen_next       = seen_reg;
        ferr_next       = ferr_reg;
        crc_next        = crc_reg;
        snap_next       = snap_reg;
        fp_next         = fp_reg;
        res_next        = res_reg;
        total           = 17'd0;
        tf              = 16'd0;
        if (take)
        begin
            if (pos < HDR_LEN)
            begin
                case (pos[4:0])
                    5'd0:
                    begin
                        type_field_next[15:8] = b;
                        if (b >= 8'd3) header_ok_next = 1'b0;
                    end
                    5'd1: type_field_next[7:0] = b;
                    5'd2: decl_len_next[15:8] = b;
                    5'd3: decl_len_next[7:0] = b;
                    5'd4: if (b != 8'h21) header_ok_next = 1'b0;
                    5'd5: if (b != 8'h12) header_ok_next = 1'b0;
                    5'd6: if (b != 8'hA4) header_ok_next = 1'b0;
                    5'd7: if (b != 8'h42) header_ok_next = 1'b0;
                    default: ;
                endcase
            end
            else if (ferr_reg == V_OK && rel < {1'b0, decl_len_reg})
            begin
                case (phase_reg)
                    PH_SKIP, PH_FP:
                    begin
                        if (phase_reg == PH_FP) fp_next = {fp_reg[23:0], b};
                        skip_next = skip_reg - 16'd1;
                        if (skip_next == 16'd0) phase_next = PH_HDR;
                    end
                    default:
                    begin
                        if (rel[1:0] == 2'd0) snap_next = crc_reg;
                        ahdr_next = {ahdr_reg[23:0], b};
                        if (rel[1:0] == 2'd3)
                        begin
                            if (end_pos > {2'd0, decl_len_reg})
                                ferr_next = V_OVERRUN;
                            else if (seen_reg[10])
                                ferr_next = V_AFTER_FP;
                            else if (seen_reg[9] && at != 16'h8028)
                                ferr_next = V_AFTER_MI;
                            else if (known && !lok)
                                ferr_next = V_BAD_LEN;
                            else if (known && seen_reg[bit_idx])
                                ferr_next = V_DUP;
                            else
                            begin
                                if (known) seen_next[bit_idx] = 1'b1;
                                skip_next = pad_len;
                                if (pad_len == 16'd0)
                                    phase_next = PH_HDR;
                                else if (known && bit_idx == 4'd10)
                                    phase_next = PH_FP;
                                else
                                    phase_next = PH_SKIP;
                            end
                        end
                    end
                endcase
            end
            crc_next = crc_byte(crc_reg, b);
            byte_count_next = (pos < COUNT_MAX) ? pos + 17'd1 : pos;

            if (in_item.last_byte)
            begin
                total = byte_count_next;
                tf    = type_field_next;
                res_next = '0;
                if (total < HDR_LEN || !header_ok_next)
                    res_next.verdict = V_NOT_STUN;
                else
                begin
                    res_next.msg_class  = {tf[8], tf[4]};
                    res_next.msg_method = {tf[13:9], tf[7:5], tf[3:0]};
                    if ({1'b0, decl_len_next} != total - HDR_LEN || decl_len_next[1:0] != 2'd0)
                        res_next.verdict = V_LEN_MISM;
                    else
                    begin
                        res_next.attrs_present = seen_next;
                        if (ferr_next != V_OK)
                            res_next.verdict = ferr_next;
                        else if (seen_next[10] && fp_next != (~snap_next ^ FP_XOR))
                            res_next.verdict = V_FP_MISM;
                        else
                            res_next.verdict = V_OK;
                    end
                end
                byte_count_next = '0;
                type_field_next = '0;
                decl_len_next   = '0;
                header_ok_next  = 1'b1;
                ahdr_next       = '0;
                phase_next      = PH_HDR;
                skip_next       = '0;
                seen_next       = '0;
                ferr_next       = V_OK;
                crc_next        = '1;
                snap_next       = '0;
                fp_next         = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            type_field_reg <= '0;
            decl_len_reg   <= '0;
            header_ok_reg  <= 1'b1;
            ahdr_reg       <= '0;
            phase_reg      <= PH_HDR;
            skip_reg       <= '0;
            seen_reg       <= '0;
            ferr_reg       <= V_OK;
            crc_reg        <= '1;
            snap_reg       <= '0;
            fp_reg         <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            type_field_reg <= type_field_next;
            decl_len_reg   <= decl_len_next;
            header_ok_reg  <= header_ok_next;
            ahdr_reg       <= ahdr_next;
            phase_reg      <= phase_next;
            skip_reg       <= skip_next;
            seen_reg       <= seen_next;
            ferr_reg       <= ferr_next;
            crc_reg        <= crc_next;
            snap_reg       <= snap_next;
            fp_reg         <= fp_next;
            if (take && in_item.last_byte)
                ovalid_reg <= 1'b1;
            else if (!out_stall)
                ovalid_reg <= 1'b0;
        end
    end
endmodule

[design/stun_message_validator_top.sv]
// top level of the stun message validator
// Usage:
//   input channel: data_byte with last_byte, valid/stall; one transfer per byte.
//   output channel: verdict, msg_class, msg_method, attrs_present, valid/stall;
//   one transfer per message, produced by the byte carrying last_byte.
//   config: cfg_we with cfg_index (0 username max, 1 software max) and cfg_data,
//   written only while no message is in flight.
// Path: a byte enters a two-entry queue and is parsed when the parser takes it,
//   at which point the verdict is registered in the result register, from which
//   the receiver takes it.
// Throughput: one byte per cycle while the receiver does not stall a waiting
//   verdict; the parser does the header, attribute and byte-wide crc update of a byte in the cycle that it takes it.
// Reset: queue empties, parser returns to start of message, limits go to
//   513 and 763.
// Receiver stall: the verdict holds and the parser takes no byte while it
//   waits; the queue then fills and stalls the sender.
module stun_message_validator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  verdict,
    output logic [1:0]  msg_class,
    output logic [11:0] msg_method,
    output logic [10:0] attrs_present,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import stun_val_pkg::*;

    logic [15:0] user_max_reg, soft_max_reg;
    item_t       q_in, q_out;
    logic        q_valid, q_stall;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_max_reg <= 16'd513;
            soft_max_reg <= 16'd763;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_USERNAME) user_max_reg <= cfg_data;
            if (cfg_index == CFG_SOFTWARE) soft_max_reg <= cfg_data;
        end
    end

    assign q_in.data_byte = data_byte;
    assign q_in.last_byte = last_byte;

    stun_val_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (q_in),
        .out_valid (q_valid),
        .out_stall (q_stall),
        .out_item  (q_out)
    );

    stun_val_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (q_valid),
        .in_stall         (q_stall),
        .in_item          (q_out),
        .username_max_len (user_max_reg),
        .software_max_len (soft_max_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_res          (res)
    );

    assign verdict       = res.verdict;
    assign msg_class     = res.msg_class;
    assign msg_method    = res.msg_method;
    assign attrs_present = res.attrs_present;
endmodule

[tb/stun_message_validator_top_tb.sv]
// self-checking testbench for the stun message validator: byte stimulus, verdict prediction
`timescale 1ns / 1ps

module stun_message_validator_top_tb;

    import stun_val_pkg::*;

    localparam logic [15:0] AT_USERNAME  = 16'h0006;
    localparam logic [15:0] AT_PRIORITY  = 16'h0024;
    localparam logic [15:0] AT_ICE_CTRLG = 16'h802A;
    localparam logic [15:0] AT_ICE_CTRLD = 16'h8029;
    localparam logic [15:0] AT_USE_CAND  = 16'h0025;
    localparam logic [15:0] AT_NOMINATE  = 16'hC001;
    localparam logic [15:0] AT_SOFTWARE  = 16'h8022;
    localparam logic [15:0] AT_XOR_MAP   = 16'h0020;
    localparam logic [15:0] AT_ERR_CODE  = 16'h0009;
    localparam logic [15:0] AT_MSG_INTEG = 16'h0008;
    localparam logic [15:0] AT_FINGERPR  = 16'h8028;

    localparam int BIT_USERNAME = 0;
    localparam int BIT_SOFTWARE = 6;
    localparam int BIT_MSG_INTEG = 9;
    localparam int BIT_FINGERPR = 10;

    typedef struct {
        verdict_t    verdict;
        logic [1:0]  msg_class;
        logic [11:0] msg_method;
        logic [10:0] attrs_present;
    } verdict_rec_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  verdict;
    logic [1:0]  msg_class;
    logic [11:0] msg_method;
    logic [10:0] attrs_present;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    stun_message_validator_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .verdict       (verdict),
        .msg_class     (msg_class),
        .msg_method    (msg_method),
        .attrs_present (attrs_present),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    logic [15:0] attr_types [11] = '{AT_USERNAME, AT_PRIORITY, AT_ICE_CTRLG, AT_ICE_CTRLD,
                                     AT_USE_CAND, AT_NOMINATE, AT_SOFTWARE, AT_XOR_MAP,
                                     AT_ERR_CODE, AT_MSG_INTEG, AT_FINGERPR};

    // limits as the block should hold them
    logic [15:0] lim_user;
    logic [15:0] lim_soft;

    // parser state of the predictor
    logic [16:0] p_count;
    logic [15:0] p_type;
    logic [15:0] p_dlen;
    logic        p_hdr_ok;
    logic [31:0] p_shift;
    phase_t      p_phase;
    logic [15:0] p_skip;
    logic [10:0] p_seen;
    verdict_t    p_err;
    logic [31:0] p_crc;
    logic [31:0] p_snap;
    logic [31:0] p_fpval;

    verdict_rec_t verdicts_due[$];
    logic [7:0]   msg_bytes[$];

    int  mismatches;
    int  msgs_sent;
    int  bytes_sent;
    int  verdicts_seen;
    bit  tx_idle;
    bit  rx_idle;
    int  hold_req;
    bit  long_hold;
    int  rx_burst;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        end
        return r;
    endfunction

    function automatic int attr_index(logic [15:0] t);
        for (int i = 0; i < 11; i++)
        begin
            if (attr_types[i] == t)
                return i;
        end
        return -1;
    endfunction

    function automatic bit attr_len_legal(int idx, logic [31:0] n);
        case (idx)
            0:       return n <= lim_user;
            1, 5:    return n == 4;
            2, 3:    return n == 8;
            4:       return n == 0;
            6:       return n <= lim_soft;
            7:       return n == 8 || n == 20;
            8:       return n >= 4;
            9:       return n == 20;
            default: return n == 4;
        endcase
    endfunction

    function automatic void clear_parser();
        p_count  = '0;
        p_type   = '0;
        p_dlen   = '0;
        p_hdr_ok = 1'b1;
        p_shift  = '0;
        p_phase  = PH_HDR;
        p_skip   = '0;
        p_seen   = '0;
        p_err    = V_OK;
        p_crc    = 32'hFFFFFFFF;
        p_snap   = '0;
        p_fpval  = '0;
    endfunction

    function automatic void parse_attr_byte(logic [31:0] pos, logic [7:0] b);
        logic [31:0] rel;
        logic [31:0] t;
        logic [31:0] n;
        int          idx;
        rel = pos - 32'd20;
        if (p_phase != PH_HDR)
        begin
            if (p_phase == PH_FP)
                p_fpval = {p_fpval[23:0], b};
            p_skip = p_skip - 16'd1;
            if (p_skip == 0)
                p_phase = PH_HDR;
            return;
        end
        if (rel[1:0] == 2'd0)
            p_snap = p_crc;
        p_shift = {p_shift[23:0], b};
        if (rel[1:0] != 2'd3)
            return;
        t = {16'd0, p_shift[31:16]};
        n = {16'd0, p_shift[15:0]};
        if (rel + 32'd1 + n > {16'd0, p_dlen})
        begin
            p_err = V_OVERRUN;
            return;
        end
        if (p_seen[BIT_FINGERPR])
        begin
            p_err = V_AFTER_FP;
            return;
        end
        if (p_seen[BIT_MSG_INTEG] && t[15:0] != AT_FINGERPR)
        begin
            p_err = V_AFTER_MI;
            return;
        end
        idx = attr_index(t[15:0]);
        if (idx >= 0)
        begin
            if (!attr_len_legal(idx, n))
            begin
                p_err = V_BAD_LEN;
                return;
            end
            if (p_seen[idx])
            begin
                p_err = V_DUP;
                return;
            end
            p_seen[idx] = 1'b1;
        end
        p_skip = 16'((n + 32'd3) & 32'hFFFC);
        if (p_skip == 0)
            p_phase = PH_HDR;
        else
            p_phase = (idx == BIT_FINGERPR) ? PH_FP : PH_SKIP;
    endfunction

    // advance the predictor by one accepted byte, queue a verdict on the last one
    function automatic void predict_byte(logic [7:0] b, logic l);
        logic [31:0]  pos;
        logic [31:0]  total;
        verdict_rec_t r;
        pos = {15'd0, p_count};
        if (pos < 20)
        begin
            case (pos)
                0: begin p_type[15:8] = b; if (b >= 8'd3) p_hdr_ok = 1'b0; end
                1: p_type[7:0] = b;
                2: p_dlen[15:8] = b;
                3: p_dlen[7:0] = b;
                4: if (b != 8'h21) p_hdr_ok = 1'b0;
                5: if (b != 8'h12) p_hdr_ok = 1'b0;
                6: if (b != 8'hA4) p_hdr_ok = 1'b0;
                7: if (b != 8'h42) p_hdr_ok = 1'b0;
                default: ;
            endcase
        end
        else if (p_err == V_OK && pos - 32'd20 < {16'd0, p_dlen})
            parse_attr_byte(pos, b);
        p_crc = crc32_step(p_crc, b);
        if (p_count != 17'h1FFFF)
            p_count = p_count + 17'd1;
        if (!l)
            return;
        total = {15'd0, p_count};
        r.verdict       = V_OK;
        r.msg_class     = '0;
        r.msg_method    = '0;
        r.attrs_present = '0;
        if (total < 20 || !p_hdr_ok)
            r.verdict = V_NOT_STUN;
        else
        begin
            r.msg_class  = {p_type[8], p_type[4]};
            r.msg_method = {p_type[13:9], p_type[7:5], p_type[3:0]};
            if ({16'd0, p_dlen} != total - 32'd20 || p_dlen[1:0] != 2'd0)
                r.verdict = V_LEN_MISM;
            else
            begin
                r.attrs_present = p_seen;
                if (p_err != V_OK)
                    r.verdict = p_err;
                else if (p_seen[BIT_FINGERPR] && p_fpval != (~p_snap ^ FP_XOR))
                    r.verdict = V_FP_MISM;
            end
        end
        verdicts_due.push_back(r);
        clear_parser();
    endfunction

    // input side: one byte transfer, with an optional idle burst first
    task automatic send_byte(logic [7:0] b, logic l);
        bit stalled;
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        forever
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
            if (!stalled)
                break;
        end
        predict_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
        msgs_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(logic [0:0] idx, logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_USERNAME)
            lim_user = v;
        else
            lim_soft = v;
    endtask

    // message building
    task automatic put_header(logic [15:0] t);
        msg_bytes.push_back(t[15:8]);
        msg_bytes.push_back(t[7:0]);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'h21);
        msg_bytes.push_back(8'h12);
        msg_bytes.push_back(8'hA4);
        msg_bytes.push_back(8'h42);
        repeat (12) msg_bytes.push_back(8'($urandom));
    endtask

    task automatic put_attr(logic [15:0] t, int n);
        msg_bytes.push_back(t[15:8]);
        msg_bytes.push_back(t[7:0]);
        msg_bytes.push_back(8'(n >> 8));
        msg_bytes.push_back(8'(n));
        repeat (n) msg_bytes.push_back(8'($urandom));
        while (msg_bytes.size() % 4 != 0)
            msg_bytes.push_back(8'($urandom));
    endtask

    task automatic set_len(int extra);
        int n;
        n = msg_bytes.size() - 20 + extra;
        msg_bytes[2] = 8'(n >> 8);
        msg_bytes[3] = 8'(n);
    endtask

    task automatic put_fingerprint(bit corrupt);
        logic [31:0] c;
        set_len(8);
        c = 32'hFFFFFFFF;
        foreach (msg_bytes[i])
            c = crc32_step(c, msg_bytes[i]);
        c = ~c ^ FP_XOR;
        if (corrupt)
            c[$urandom_range(0, 31)] ^= 1'b1;
        msg_bytes.push_back(AT_FINGERPR[15:8]);
        msg_bytes.push_back(AT_FINGERPR[7:0]);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'h04);
        for (int k = 3; k >= 0; k--)
            msg_bytes.push_back(c[8*k +: 8]);
    endtask

    function automatic int good_len(int idx);
        case (idx)
            0:       return $urandom_range(0, lim_user < 24 ? lim_user : 24);
            6:       return $urandom_range(0, lim_soft < 24 ? lim_soft : 24);
            1, 5, 10: return 4;
            2, 3:    return 8;
            4:       return 0;
            7:       return $urandom_range(0, 1) ? 8 : 20;
            8:       return $urandom_range(4, 24);
            default: return 20;
        endcase
    endfunction

    function automatic int bad_len(int idx);
        case (idx)
            0:       return lim_user < 1000 ? lim_user + 1 : good_len(idx);
            6:       return lim_soft < 1000 ? lim_soft + 1 : good_len(idx);
            1, 5, 10: return $urandom_range(0, 3);
            2, 3:    return $urandom_range(0, 1) ? 4 : 12;
            4:       return 4;
            7:       return 12;
            8:       return $urandom_range(0, 3);
            default: return 16;
        endcase
    endfunction

    task automatic put_random_attr();
        int          idx;
        logic [15:0] t;
        if ($urandom_range(0, 9) < 7)
        begin
            idx = $urandom_range(0, 8);
            put_attr(attr_types[idx], $urandom_range(0, 19) == 0 ? bad_len(idx) : good_len(idx));
        end
        else
        begin
            do t = 16'($urandom); while (attr_index(t) >= 0);
            put_attr(t, $urandom_range(0, 12));
        end
    endtask

    task automatic build_random_msg();
        int n;
        msg_bytes.delete();
        if ($urandom_range(0, 9) < 8)
        begin
            put_header({8'($urandom_range(0, 2)), 8'($urandom)});
            repeat ($urandom_range(0, 5)) put_random_attr();
            // an attribute whose declared length runs past the four value bytes that follow it
            if ($urandom_range(0, 14) == 0)
            begin
                msg_bytes.push_back(8'($urandom));
                msg_bytes.push_back(8'($urandom));
                msg_bytes.push_back(8'h00);
                msg_bytes.push_back(8'($urandom_range(8, 40)));
                repeat (4) msg_bytes.push_back(8'($urandom));
            end
            if ($urandom_range(0, 3) == 0)
                put_attr(AT_MSG_INTEG, $urandom_range(0, 9) == 0 ? 16 : 20);
            if ($urandom_range(0, 1))
                put_fingerprint($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0)
                put_random_attr();
            set_len(0);
            case ($urandom_range(0, 14))
                0: set_len(4 * $urandom_range(1, 3));
                1: set_len(-$urandom_range(1, 3));
                2: repeat ($urandom_range(1, 5)) msg_bytes.push_back(8'($urandom));
                3: repeat ($urandom_range(1, 5)) void'(msg_bytes.pop_back());
                default: ;
            endcase
        end
        else
        begin
            n = $urandom_range(1, 40);
            repeat (n) msg_bytes.push_back(8'($urandom));
            if (n >= 8 && $urandom_range(0, 1))
            begin
                msg_bytes[0] = 8'($urandom_range(0, 3));
                msg_bytes[4] = 8'h21;
                msg_bytes[5] = 8'h12;
                msg_bytes[6] = 8'hA4;
                msg_bytes[7] = 8'h42;
            end
        end
    endtask

    // output side: random stall bursts, plus a long hold on request
    initial
    begin
        long_hold = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                long_hold = 1'b1;
                hold_req--;
            end
            else
                long_hold = 1'b0;
        end
    end

    task automatic check_verdict();
        verdict_rec_t e;
        verdicts_seen++;
        if (verdicts_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected verdict transfer: verdict %0d class %0d method %0h attrs %0h",
                         verdict, msg_class, msg_method, attrs_present);
            return;
        end
        e = verdicts_due.pop_front();
        if (verdict !== e.verdict || msg_class !== e.msg_class ||
            msg_method !== e.msg_method || attrs_present !== e.attrs_present)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected v %0d c %0d m %03h a %03h, got v %0d c %0d m %03h a %03h",
                         e.verdict, e.msg_class, e.msg_method, e.attrs_present,
                         verdict, msg_class, msg_method, attrs_present);
        end
    endtask

    initial
    begin
        out_stall <= 1'b0;
        rx_burst = 0;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
                check_verdict();
            @(posedge clk);
            if (long_hold)
                out_stall <= 1'b1;
            else if (rx_burst > 0)
            begin
                rx_burst--;
                out_stall <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                rx_burst = $urandom_range(1, 11) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // test tasks
    task automatic test_header_checks();
        msg_bytes.push_back(8'h00);
        send_msg();
        put_header(16'h0001);
        void'(msg_bytes.pop_back());
        send_msg();
        put_header(16'h0301);
        send_msg();
        put_header(16'hFF00);
        send_msg();
        for (int k = 4; k < 8; k++)
        begin
            put_header(16'h0001);
            msg_bytes[k] = msg_bytes[k] ^ 8'h80;
            send_msg();
        end
        put_header(16'h0000);
        send_msg();
        put_header(16'h02FF);
        send_msg();
        put_header(16'h0111);
        send_msg();
    endtask

    task automatic test_length_checks();
        put_header(16'h0001);
        put_attr(AT_PRIORITY, 4);
        set_len(-4);
        send_msg();
        put_header(16'h0001);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'h00);
        set_len(0);
        send_msg();
        put_header(16'h0001);
        put_attr(AT_PRIORITY, 4);
        set_len(8);
        send_msg();
    endtask

    task automatic test_attribute_rules();
        put_header(16'h0001);
        for (int i = 0; i < 9; i++)
            put_attr(attr_types[i], good_len(i));
        put_attr(AT_MSG_INTEG, 20);
        put_fingerprint(1'b0);
        send_msg();
        put_header(16'h0101);
        put_attr(AT_PRIORITY, 4);
        put_attr(AT_PRIORITY, 4);
        set_len(0);
        send_msg();
        put_header(16'h0011);
        put_attr(AT_XOR_MAP, 12);
        set_len(0);
        send_msg();
        put_header(16'h0001);
        put_fingerprint(1'b0);
        put_attr(AT_SOFTWARE, 3);
        set_len(0);
        send_msg();
        put_header(16'h0001);
        put_attr(AT_MSG_INTEG, 20);
        put_attr(AT_USE_CAND, 0);
        set_len(0);
        send_msg();
        put_header(16'h0001);
        put_attr(16'h7F01, 5);
        put_attr(AT_NOMINATE, 4);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'h24);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'h10);
        set_len(0);
        send_msg();
        put_header(16'h0001);
        put_attr(AT_ERR_CODE, 9);
        put_fingerprint(1'b1);
        send_msg();
    endtask

    task automatic test_limits();
        wait_drained();
        write_limit(CFG_USERNAME, 16'd0);
        write_limit(CFG_SOFTWARE, 16'd0);
        put_header(16'h0001);
        put_attr(AT_USERNAME, 0);
        put_attr(AT_SOFTWARE, 0);
        set_len(0);
        send_msg();
        put_header(16'h0001);
        put_attr(AT_USERNAME, 1);
        set_len(0);
        send_msg();
        wait_drained();
        write_limit(CFG_USERNAME, 16'hFFFF);
        write_limit(CFG_SOFTWARE, 16'hFFFF);
        put_header(16'h0001);
        put_attr(AT_USERNAME, 40);
        put_attr(AT_SOFTWARE, 60);
        set_len(0);
        send_msg();
        wait_drained();
        write_limit(CFG_USERNAME, 16'd8);
        write_limit(CFG_SOFTWARE, 16'd12);
        put_header(16'h0001);
        put_attr(AT_USERNAME, 8);
        put_attr(AT_SOFTWARE, 12);
        set_len(0);
        send_msg();
        put_header(16'h0001);
        put_attr(AT_SOFTWARE, 13);
        set_len(0);
        send_msg();
        wait_drained();
        write_limit(CFG_USERNAME, 16'd513);
        write_limit(CFG_SOFTWARE, 16'd763);
        put_header(16'h0001);
        put_attr(AT_USERNAME, 20);
        put_attr(AT_SOFTWARE, 30);
        set_len(0);
        send_msg();
    endtask

    // declared length far beyond the bytes that arrive
    task automatic test_long_message();
        put_header(16'h0001);
        msg_bytes[2] = 8'hFF;
        msg_bytes[3] = 8'hFC;
        repeat (100) msg_bytes.push_back(8'($urandom));
        send_msg();
    endtask

    task automatic test_backpressure();
        hold_req = 300;
        repeat (4)
        begin
            build_random_msg();
            send_msg();
        end
    endtask

    task automatic test_random(int byte_goal, int msg_goal);
        int b0;
        int m0;
        b0 = bytes_sent;
        m0 = msgs_sent;
        while (bytes_sent - b0 < byte_goal || msgs_sent - m0 < msg_goal)
        begin
            build_random_msg();
            send_msg();
            // change limits now and then between messages
            if ($urandom_range(0, 24) == 0)
            begin
                wait_drained();
                write_limit(1'($urandom_range(0, 1)),
                            $urandom_range(0, 1) ? 16'($urandom_range(0, 30)) : 16'($urandom));
            end
        end
    endtask

    initial
    begin
        #200_000_000;
        $display("timeout: %0d verdicts still outstanding", verdicts_due.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= 8'h00;
        last_byte <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_USERNAME;
        cfg_data  <= 16'h0000;
        lim_user  = 16'd513;
        lim_soft  = 16'd763;
        mismatches = 0;
        msgs_sent = 0;
        bytes_sent = 0;
        verdicts_seen = 0;
        hold_req = 0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        clear_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_header_checks();
        test_length_checks();
        test_attribute_rules();
        test_limits();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_long_message();
        test_backpressure();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_random(200, 3);
        wait_drained();
        write_limit(CFG_USERNAME, 16'd513);
        write_limit(CFG_SOFTWARE, 16'd763);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random(100, 2);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("covered %0d messages, %0d bytes, %0d verdicts checked", msgs_sent,
                 bytes_sent, verdicts_seen);
        $display("header, length, attribute order and limit rules, crc check, stalls");
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("Verification passed");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
